/* sv/sbpm_pkg.sv */
// ----------------------------------------------------------------------------
// sbpm_pkg
// Shared types and codes of the sized buffer pool manager.
// ----------------------------------------------------------------------------
package sbpm_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_ADD_REF = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FREE      = 3'd3,
		ST_BAD       = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CLS_LO  = 2'd0,
		CLS_MID = 2'd1,
		CLS_HI  = 2'd2
	} cls_t;

	localparam int unsigned NUM_CLASSES = 3;
	localparam logic [7:0]  REF_MAX     = 8'd255;

endpackage

/* sv/sized_buffer_pool_manager.sv */
// ----------------------------------------------------------------------------
// sized_buffer_pool_manager
// Descriptor manager for a three-class packet buffer pool with per-buffer
// reference counts and per-class usage statistics.
// ----------------------------------------------------------------------------
// Each request transaction (allocate, add reference or release) yields exactly
// one result transaction. A request is captured in an input register and is
// processed once the output register is free or drains, when its result is
// loaded into the output register. The block takes one request every cycle
// while the receiver does not stall results: the free list heads, the link
// table, the reference counts and the class counters are all read and updated
// by a single combinational pass between the input register and the output
// register, so back-to-back requests always see the state left by their
// predecessor. The request side stalls only while the output register holds
// an untaken result and the input register is full.
// Allocation picks the tightest class that fits requested_size and pops that
// class's LIFO free list; at reset each list is chained so its highest slot
// leaves first. A release that drops a count to zero pushes the buffer back.
// An exhausted class fails at once. Handles number small slots first, then
// medium, then large.
// ----------------------------------------------------------------------------
module sized_buffer_pool_manager
	import sbpm_pkg::*;
#(
	parameter int unsigned SMALL_SLOTS  = 8,
	parameter int unsigned MEDIUM_SLOTS = 8,
	parameter int unsigned LARGE_SLOTS  = 8,
	parameter int unsigned SMALL_BYTES  = 128,
	parameter int unsigned MEDIUM_BYTES = 512,
	parameter int unsigned LARGE_BYTES  = 1536
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] requested_size,
	input  logic [4:0]  buffer_handle,

	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [4:0]  granted_handle,
	output logic [1:0]  size_class,
	output logic [15:0] capacity_bytes,
	output logic [7:0]  refs_after,
	output logic [7:0]  class_in_use,
	output logic [7:0]  class_peak,
	output logic [31:0] class_allocs,
	output logic [31:0] class_releases,
	output logic [31:0] failed_allocs
);

	localparam int unsigned TOTAL_SLOTS = SMALL_SLOTS + MEDIUM_SLOTS + LARGE_SLOTS;
	localparam int unsigned SW          = $clog2(TOTAL_SLOTS);

	localparam logic [7:0]  TOTAL8  = 8'(TOTAL_SLOTS);
	localparam logic [7:0]  S_END8  = 8'(SMALL_SLOTS);
	localparam logic [7:0]  M_END8  = 8'(SMALL_SLOTS + MEDIUM_SLOTS);
	localparam logic [15:0] S_BYTES = 16'(SMALL_BYTES);
	localparam logic [15:0] M_BYTES = 16'(MEDIUM_BYTES);
	localparam logic [15:0] L_BYTES = 16'(LARGE_BYTES);

	function automatic logic [7:0] cls_slots(input logic [1:0] c);
		case (c)
			CLS_LO:  return 8'(SMALL_SLOTS);
			CLS_MID: return 8'(MEDIUM_SLOTS);
			default: return 8'(LARGE_SLOTS);
		endcase
	endfunction

	function automatic logic [15:0] cls_bytes(input logic [1:0] c);
		case (c)
			CLS_LO:  return S_BYTES;
			CLS_MID: return M_BYTES;
			default: return L_BYTES;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Pool state
	// ------------------------------------------------------------------
	logic [SW-1:0] link_q     [TOTAL_SLOTS];
	logic [7:0]    refcnt_q   [TOTAL_SLOTS];
	logic [SW-1:0] head_q     [NUM_CLASSES];
	logic [7:0]    in_use_q   [NUM_CLASSES];
	logic [7:0]    peak_q     [NUM_CLASSES];
	logic [31:0]   allocs_q   [NUM_CLASSES];
	logic [31:0]   releases_q [NUM_CLASSES];
	logic [31:0]   fail_q;

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	logic        valid_s1;
	op_t         op_s1;
	logic [15:0] size_s1;
	logic [4:0]  handle_s1;

	logic req_fire;
	logic proc;

	// Process the held request whenever the output register is free or drains.
	assign proc      = valid_s1 && (!rsp_valid || !rsp_stall);
	assign req_stall = valid_s1 && !proc;
	assign req_fire  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1     <= op_t'(operation);
			size_s1   <= requested_size;
			handle_s1 <= buffer_handle;
		end
	end

	// ------------------------------------------------------------------
	// Request evaluation
	// ------------------------------------------------------------------
	logic [7:0]    h_ext;
	logic [SW-1:0] h_idx;
	logic          h_in;
	logic [1:0]    h_cls;
	logic          sz_ok;
	logic [1:0]    sz_cls;
	logic [1:0]    cls;
	logic [SW-1:0] head_c;
	logic [7:0]    in_use_c;
	logic [7:0]    rc_h;

	logic          do_pop;
	logic          do_push;
	logic          do_fail;
	logic          show_cls;
	status_t       st;
	logic [4:0]    gh;
	logic [7:0]    refs;

	logic          rc_we;
	logic [SW-1:0] rc_waddr;
	logic [7:0]    rc_wdata;
	logic          link_we;
	logic [SW-1:0] link_waddr;
	logic [SW-1:0] link_wdata;
	logic          head_we;
	logic [SW-1:0] head_wdata;

	logic [7:0]    in_use_n;
	logic [7:0]    peak_n;
	logic [31:0]   allocs_n;
	logic [31:0]   releases_n;
	logic [31:0]   fail_n;

	always_comb begin
		h_ext = 8'(handle_s1);
		h_idx = h_ext[SW-1:0];
		h_in  = h_ext < TOTAL8;
		if (h_ext < S_END8) begin
			h_cls = CLS_LO;
		end else if (h_ext < M_END8) begin
			h_cls = CLS_MID;
		end else begin
			h_cls = CLS_HI;
		end

		// Tightest class that holds the requested size.
		sz_ok = 1'b1;
		if (size_s1 <= S_BYTES) begin
			sz_cls = CLS_LO;
		end else if (size_s1 <= M_BYTES) begin
			sz_cls = CLS_MID;
		end else if (size_s1 <= L_BYTES) begin
			sz_cls = CLS_HI;
		end else begin
			sz_cls = CLS_LO;
			sz_ok  = 1'b0;
		end

		cls      = (op_s1 == OP_ALLOC) ? sz_cls : h_cls;
		head_c   = head_q[cls];
		in_use_c = in_use_q[cls];
		rc_h     = refcnt_q[h_idx];

		do_pop     = 1'b0;
		do_push    = 1'b0;
		do_fail    = 1'b0;
		show_cls   = 1'b0;
		st         = ST_BAD;
		gh         = 5'd0;
		refs       = 8'd0;
		rc_we      = 1'b0;
		rc_waddr   = h_idx;
		rc_wdata   = 8'd0;
		link_we    = 1'b0;
		link_waddr = h_idx;
		link_wdata = head_c;
		head_we    = 1'b0;
		head_wdata = h_idx;

		case (op_s1)
			OP_ALLOC: begin
				if (!sz_ok) begin
					st      = ST_TOO_LARGE;
					do_fail = 1'b1;
				end else if (in_use_c >= cls_slots(cls)) begin
					st       = ST_EXHAUSTED;
					do_fail  = 1'b1;
					show_cls = 1'b1;
				end else begin
					// Pop: head moves to its link, the popped slot links to itself.
					st         = ST_OK;
					do_pop     = 1'b1;
					show_cls   = 1'b1;
					gh         = 5'(head_c);
					refs       = 8'd1;
					head_we    = 1'b1;
					head_wdata = link_q[head_c];
					link_we    = 1'b1;
					link_waddr = head_c;
					link_wdata = head_c;
					rc_we      = 1'b1;
					rc_waddr   = head_c;
					rc_wdata   = 8'd1;
				end
			end
			OP_ADD_REF, OP_RELEASE: begin
				gh = handle_s1;
				if (!h_in) begin
					st = ST_BAD;
				end else if (rc_h == 8'd0) begin
					st       = ST_FREE;
					show_cls = 1'b1;
				end else if (op_s1 == OP_ADD_REF) begin
					show_cls = 1'b1;
					if (rc_h == REF_MAX) begin
						st   = ST_BAD;
						refs = REF_MAX;
					end else begin
						st       = ST_OK;
						refs     = rc_h + 8'd1;
						rc_we    = 1'b1;
						rc_wdata = rc_h + 8'd1;
					end
				end else begin
					st       = ST_OK;
					show_cls = 1'b1;
					refs     = rc_h - 8'd1;
					rc_we    = 1'b1;
					rc_wdata = rc_h - 8'd1;
					if (rc_h == 8'd1) begin
						// Push the freed buffer back on its class list.
						do_push = 1'b1;
						link_we = 1'b1;
						head_we = 1'b1;
					end
				end
			end
			default: begin
				st = ST_BAD;
			end
		endcase

		// Class statistics after this request.
		if (do_pop) begin
			in_use_n = in_use_c + 8'd1;
		end else if (do_push && in_use_c != 8'd0) begin
			in_use_n = in_use_c - 8'd1;
		end else begin
			in_use_n = in_use_c;
		end
		peak_n     = (in_use_n > peak_q[cls]) ? in_use_n : peak_q[cls];
		allocs_n   = allocs_q[cls] + 32'(do_pop);
		releases_n = releases_q[cls] + 32'(do_push);
		fail_n     = fail_q + 32'(do_fail);
	end

	// ------------------------------------------------------------------
	// State update
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_SLOTS; i++) begin
				refcnt_q[i] <= 8'd0;
				if (i == 0 || i == SMALL_SLOTS || i == SMALL_SLOTS + MEDIUM_SLOTS) begin
					link_q[i] <= SW'(i);
				end else begin
					link_q[i] <= SW'(i - 1);
				end
			end
			head_q[CLS_LO]  <= SW'(SMALL_SLOTS - 1);
			head_q[CLS_MID] <= SW'(SMALL_SLOTS + MEDIUM_SLOTS - 1);
			head_q[CLS_HI]  <= SW'(TOTAL_SLOTS - 1);
			for (int c = 0; c < NUM_CLASSES; c++) begin
				in_use_q[c]   <= 8'd0;
				peak_q[c]     <= 8'd0;
				allocs_q[c]   <= 32'd0;
				releases_q[c] <= 32'd0;
			end
			fail_q <= 32'd0;
		end else if (proc) begin
			if (rc_we) begin
				refcnt_q[rc_waddr] <= rc_wdata;
			end
			if (link_we) begin
				link_q[link_waddr] <= link_wdata;
			end
			if (head_we) begin
				head_q[cls] <= head_wdata;
			end
			// The selected class's counters are written even when unchanged; other classes keep theirs.
			in_use_q[cls]   <= in_use_n;
			peak_q[cls]     <= peak_n;
			allocs_q[cls]   <= allocs_n;
			releases_q[cls] <= releases_n;
			fail_q          <= fail_n;
		end
	end

	// ------------------------------------------------------------------
	// Output register: load on process, drop valid when taken
	// ------------------------------------------------------------------
	logic          rsp_valid_q;
	logic [2:0]    status_q;
	logic [4:0]    handle_q;
	logic [1:0]    class_q;
	logic [15:0]   capacity_q;
	logic [7:0]    refs_q;
	logic [7:0]    in_use_out_q;
	logic [7:0]    peak_out_q;
	logic [31:0]   allocs_out_q;
	logic [31:0]   releases_out_q;
	logic [31:0]   fail_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (proc) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			status_q   <= st;
			handle_q   <= gh;
			fail_out_q <= fail_n;
			if (show_cls) begin
				class_q        <= cls;
				capacity_q     <= cls_bytes(cls);
				refs_q         <= refs;
				in_use_out_q   <= in_use_n;
				peak_out_q     <= peak_n;
				allocs_out_q   <= allocs_n;
				releases_out_q <= releases_n;
			end else begin
				class_q        <= 2'd0;
				capacity_q     <= 16'd0;
				refs_q         <= 8'd0;
				in_use_out_q   <= 8'd0;
				peak_out_q     <= 8'd0;
				allocs_out_q   <= 32'd0;
				releases_out_q <= 32'd0;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign granted_handle = handle_q;
	assign size_class     = class_q;
	assign capacity_bytes = capacity_q;
	assign refs_after     = refs_q;
	assign class_in_use   = in_use_out_q;
	assign class_peak     = peak_out_q;
	assign class_allocs   = allocs_out_q;
	assign class_releases = releases_out_q;
	assign failed_allocs  = fail_out_q;

endmodule

/* sv/sbpm_checker.sv */
// ----------------------------------------------------------------------------
// sbpm_checker
// Port-level checks of the sized buffer pool manager, bound to the top level.
// ----------------------------------------------------------------------------
module sbpm_checker
	import sbpm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [2:0]  status,
	input logic [4:0]  granted_handle,
	input logic [1:0]  size_class,
	input logic [15:0] capacity_bytes,
	input logic [7:0]  refs_after,
	input logic [31:0] failed_allocs
);

	// A stalled result transaction stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	// A stalled result transaction keeps its status, handle, reference count and failure count.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(status) && $stable(granted_handle)
			&& $stable(refs_after) && $stable(failed_allocs))
		else $error("result payload changed while stalled");

	// An oversize request reports no class and no buffer.
	a_too_large: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_TOO_LARGE |-> granted_handle == 5'd0
			&& size_class == 2'd0 && capacity_bytes == 16'd0 && refs_after == 8'd0)
		else $error("oversize result carries class data");

	// A refused allocation grants nothing.
	a_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EXHAUSTED |-> granted_handle == 5'd0
			&& refs_after == 8'd0 && capacity_bytes != 16'd0)
		else $error("exhausted result grants a buffer");

endmodule

bind sized_buffer_pool_manager sbpm_checker u_sbpm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.status         (status),
	.granted_handle (granted_handle),
	.size_class     (size_class),
	.capacity_bytes (capacity_bytes),
	.refs_after     (refs_after),
	.failed_allocs  (failed_allocs)
);

/* bench/sbpm_bench_pkg.sv */
// ----------------------------------------------------------------------------
// sbpm_bench_pkg
// Pool geometry, the result record and the buffer pool ledger that predicts
// and checks each result of the sized buffer pool manager.
// ----------------------------------------------------------------------------
package sbpm_bench_pkg;
	import sbpm_pkg::*;

	localparam int unsigned POOL_SMALL_SLOTS  = 8;
	localparam int unsigned POOL_MEDIUM_SLOTS = 8;
	localparam int unsigned POOL_LARGE_SLOTS  = 8;
	localparam int unsigned POOL_SMALL_BYTES  = 128;
	localparam int unsigned POOL_MEDIUM_BYTES = 512;
	localparam int unsigned POOL_LARGE_BYTES  = 1536;
	localparam int unsigned POOL_SLOTS =
		POOL_SMALL_SLOTS + POOL_MEDIUM_SLOTS + POOL_LARGE_SLOTS;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  handle;
		logic [1:0]  cls;
		logic [15:0] capacity;
		logic [7:0]  refs;
		logic [7:0]  in_use;
		logic [7:0]  peak;
		logic [31:0] allocs;
		logic [31:0] releases;
		logic [31:0] failed;
	} pool_reply_t;

	class pool_ledger;
		logic [4:0]  link_of   [POOL_SLOTS];
		logic [7:0]  use_count [POOL_SLOTS];
		logic [4:0]  head_of   [NUM_CLASSES];
		logic [7:0]  in_use    [NUM_CLASSES];
		logic [7:0]  peak      [NUM_CLASSES];
		logic [31:0] allocs    [NUM_CLASSES];
		logic [31:0] releases  [NUM_CLASSES];
		logic [31:0] failures;
		pool_reply_t owed_replies [$];
		int          errors;

		function int unsigned first_slot(cls_t c);
			case (c)
				CLS_LO:  return 0;
				CLS_MID: return POOL_SMALL_SLOTS;
				default: return POOL_SMALL_SLOTS + POOL_MEDIUM_SLOTS;
			endcase
		endfunction

		function int unsigned slot_count(cls_t c);
			case (c)
				CLS_LO:  return POOL_SMALL_SLOTS;
				CLS_MID: return POOL_MEDIUM_SLOTS;
				default: return POOL_LARGE_SLOTS;
			endcase
		endfunction

		function int unsigned byte_size(cls_t c);
			case (c)
				CLS_LO:  return POOL_SMALL_BYTES;
				CLS_MID: return POOL_MEDIUM_BYTES;
				default: return POOL_LARGE_BYTES;
			endcase
		endfunction

		function cls_t class_of(int unsigned h);
			if (h < POOL_SMALL_SLOTS) return CLS_LO;
			if (h < POOL_SMALL_SLOTS + POOL_MEDIUM_SLOTS) return CLS_MID;
			return CLS_HI;
		endfunction

		// Chain every class so its highest slot leaves first.
		function void clear();
			foreach (use_count[i]) use_count[i] = '0;
			for (int k = 0; k < NUM_CLASSES; k++) begin
				cls_t c;
				int unsigned f;
				c = cls_t'(k);
				f = first_slot(c);
				for (int unsigned i = 0; i < slot_count(c); i++)
					link_of[f + i] = 5'((i == 0) ? f : f + i - 1);
				head_of[c]  = 5'(f + slot_count(c) - 1);
				in_use[c]   = '0;
				peak[c]     = '0;
				allocs[c]   = '0;
				releases[c] = '0;
			end
			failures = '0;
			errors   = 0;
			owed_replies.delete();
		endfunction

		function pool_reply_t summarize(status_t st, logic [4:0] h, bit has_cls,
				cls_t c, logic [7:0] refs);
			pool_reply_t r;
			r = '0;
			r.status = st;
			r.handle = h;
			if (has_cls) begin
				r.cls      = c;
				r.capacity = 16'(byte_size(c));
				r.refs     = refs;
				r.in_use   = in_use[c];
				r.peak     = peak[c];
				r.allocs   = allocs[c];
				r.releases = releases[c];
			end
			r.failed = failures;
			return r;
		endfunction

		function pool_reply_t predict(op_t op, logic [15:0] size, logic [4:0] h);
			cls_t c;
			int unsigned b;
			case (op)
				OP_ALLOC: begin
					if (size <= POOL_SMALL_BYTES) c = CLS_LO;
					else if (size <= POOL_MEDIUM_BYTES) c = CLS_MID;
					else if (size <= POOL_LARGE_BYTES) c = CLS_HI;
					else begin
						failures++;
						return summarize(ST_TOO_LARGE, '0, 1'b0, CLS_LO, '0);
					end
					if (in_use[c] >= slot_count(c)) begin
						failures++;
						return summarize(ST_EXHAUSTED, '0, 1'b1, c, '0);
					end
					b = head_of[c];
					if (b >= POOL_SLOTS) b = first_slot(c);
					head_of[c]   = link_of[b];
					link_of[b]   = 5'(b);
					use_count[b] = 8'd1;
					in_use[c]++;
					if (in_use[c] > peak[c]) peak[c] = in_use[c];
					allocs[c]++;
					return summarize(ST_OK, 5'(b), 1'b1, c, 8'd1);
				end
				OP_NONE: return summarize(ST_BAD, '0, 1'b0, CLS_LO, '0);
				default: ;
			endcase
			if (h >= POOL_SLOTS) return summarize(ST_BAD, h, 1'b0, CLS_LO, '0);
			c = class_of(h);
			if (use_count[h] == 0) return summarize(ST_FREE, h, 1'b1, c, '0);
			if (op == OP_ADD_REF) begin
				if (use_count[h] == REF_MAX) return summarize(ST_BAD, h, 1'b1, c, REF_MAX);
				use_count[h]++;
				return summarize(ST_OK, h, 1'b1, c, use_count[h]);
			end
			use_count[h]--;
			if (use_count[h] == 0) begin
				link_of[h] = head_of[c];
				head_of[c] = h;
				if (in_use[c] != 0) in_use[c]--;
				releases[c]++;
			end
			return summarize(ST_OK, h, 1'b1, c, use_count[h]);
		endfunction

		function void note_request(op_t op, logic [15:0] size, logic [4:0] h);
			owed_replies.push_back(predict(op, size, h));
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0d, got %0d", field, want, seen);
				errors++;
			end
		endfunction

		function void check_reply(pool_reply_t seen);
			pool_reply_t want;
			if (owed_replies.size() == 0) begin
				$error("unexpected result: status %0d, handle %0d", seen.status, seen.handle);
				errors++;
				return;
			end
			want = owed_replies.pop_front();
			compare("status",         32'(want.status),   32'(seen.status));
			compare("granted_handle", 32'(want.handle),   32'(seen.handle));
			compare("size_class",     32'(want.cls),      32'(seen.cls));
			compare("capacity_bytes", 32'(want.capacity), 32'(seen.capacity));
			compare("refs_after",     32'(want.refs),     32'(seen.refs));
			compare("class_in_use",   32'(want.in_use),   32'(seen.in_use));
			compare("class_peak",     32'(want.peak),     32'(seen.peak));
			compare("class_allocs",   want.allocs,        seen.allocs);
			compare("class_releases", want.releases,      seen.releases);
			compare("failed_allocs",  want.failed,        seen.failed);
		endfunction

		function int pending();
			return owed_replies.size();
		endfunction

		function int pick_held();
			int held [$];
			foreach (use_count[i])
				if (use_count[i] != 0) held.push_back(i);
			if (held.size() == 0) return -1;
			return held[$urandom_range(held.size() - 1)];
		endfunction
	endclass

endpackage

/* bench/tb_sized_buffer_pool_manager.sv */
// ----------------------------------------------------------------------------
// tb_sized_buffer_pool_manager
// Drives allocate, add reference and release transactions into the buffer
// pool manager and checks every result against a ledger that tracks the free
// lists, reference counts and class statistics, under varied idling.
// ----------------------------------------------------------------------------
module tb_sized_buffer_pool_manager;
	import sbpm_pkg::*;
	import sbpm_bench_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS     = 1300;
	localparam int PHASE_ITEMS     = 150;
	localparam int PRESSURE_AT     = 310;
	localparam int PRESSURE_CYCLES = 80;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int SETTLE_CYCLES   = 8;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        req_valid      = 1'b0;
	logic        req_stall;
	logic [1:0]  operation      = OP_ALLOC;
	logic [15:0] requested_size = '0;
	logic [4:0]  buffer_handle  = '0;
	logic        rsp_valid;
	logic        rsp_stall      = 1'b0;
	logic [2:0]  status;
	logic [4:0]  granted_handle;
	logic [1:0]  size_class;
	logic [15:0] capacity_bytes;
	logic [7:0]  refs_after;
	logic [7:0]  class_in_use;
	logic [7:0]  class_peak;
	logic [31:0] class_allocs;
	logic [31:0] class_releases;
	logic [31:0] failed_allocs;

	pool_ledger ledger;
	int         sent      = 0;
	int         idle_pct  = 0;
	int         stall_pct = 0;
	bit         want_hold = 1'b0;
	int         hold_left = 0;
	bit         saturated = 1'b0;
	int         waited;
	int         pick;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sized_buffer_pool_manager #(
		.SMALL_SLOTS  (POOL_SMALL_SLOTS),
		.MEDIUM_SLOTS (POOL_MEDIUM_SLOTS),
		.LARGE_SLOTS  (POOL_LARGE_SLOTS),
		.SMALL_BYTES  (POOL_SMALL_BYTES),
		.MEDIUM_BYTES (POOL_MEDIUM_BYTES),
		.LARGE_BYTES  (POOL_LARGE_BYTES)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.operation      (operation),
		.requested_size (requested_size),
		.buffer_handle  (buffer_handle),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.granted_handle (granted_handle),
		.size_class     (size_class),
		.capacity_bytes (capacity_bytes),
		.refs_after     (refs_after),
		.class_in_use   (class_in_use),
		.class_peak     (class_peak),
		.class_allocs   (class_allocs),
		.class_releases (class_releases),
		.failed_allocs  (failed_allocs)
	);

	// Pick a random size that lands in the given class.
	function automatic logic [15:0] size_for(cls_t c);
		case (c)
			CLS_LO:  return 16'($urandom_range(POOL_SMALL_BYTES));
			CLS_MID: return 16'($urandom_range(POOL_MEDIUM_BYTES, POOL_SMALL_BYTES + 1));
			default: return 16'($urandom_range(POOL_LARGE_BYTES, POOL_MEDIUM_BYTES + 1));
		endcase
	endfunction

	// Offer one request transaction and hold it until the block takes it.
	// Always entered right after a rising edge, so valid gets one update per step.
	task automatic send_request(input op_t op, input logic [15:0] size, input logic [4:0] h);
		// Rotate the idling mix: none, sender idle, receiver stalling, both.
		case ((sent / PHASE_ITEMS) % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 53; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 53; end
			default: begin idle_pct = 14; stall_pct = 14; end
		endcase
		// Ask the receiver for one long hold-off while the sender keeps going.
		if (sent == PRESSURE_AT) want_hold = 1'b1;
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_valid      <= 1'b1;
		operation      <= op;
		requested_size <= size;
		buffer_handle  <= h;
		do @(posedge clk); while (req_stall);
		ledger.note_request(op, size, h);
		sent++;
	endtask

	// Ask one class for two more buffers than it has slots, so it fills and then refuses.
	task automatic exhaust_class(input cls_t c);
		int n;
		n = ledger.slot_count(c) + 2;
		repeat (n) send_request(OP_ALLOC, size_for(c), 5'($urandom_range(31)));
	endtask

	// Return every held buffer to its pool, starting at a random slot.
	task automatic drain_pool();
		int start;
		int h;
		start = $urandom_range(POOL_SLOTS - 1);
		for (int k = 0; k < POOL_SLOTS; k++) begin
			h = (start + k) % POOL_SLOTS;
			while (ledger.use_count[h] != 0)
				send_request(OP_RELEASE, 16'($urandom), 5'(h));
		end
	endtask

	// Push one held buffer's count up to the ceiling and past it.
	task automatic saturate_one();
		int h;
		int n;
		h = ledger.pick_held();
		if (h < 0) begin
			send_request(OP_ALLOC, size_for(cls_t'($urandom_range(2))), 5'($urandom_range(31)));
			h = ledger.pick_held();
		end
		if (h < 0) return;
		n = int'(REF_MAX) - int'(ledger.use_count[h]) + 2;
		repeat (n) send_request(OP_ADD_REF, 16'($urandom), 5'(h));
		saturated = 1'b1;
	endtask

	// One transaction from the everyday mix; most touch buffers actually held.
	task automatic send_mixed();
		int roll;
		int held;
		roll = $urandom_range(99);
		held = ledger.pick_held();
		if (roll < 35 || held < 0) begin
			if ($urandom_range(9) < 9)
				send_request(OP_ALLOC, size_for(cls_t'($urandom_range(2))),
					5'($urandom_range(31)));
			else
				send_request(OP_ALLOC, 16'($urandom), 5'($urandom_range(31)));
		end else if (roll < 60) begin
			send_request(OP_ADD_REF, 16'($urandom), 5'(held));
		end else if (roll < 90) begin
			send_request(OP_RELEASE, 16'($urandom), 5'(held));
		end else begin
			// Noise: any operation code, any size, any handle.
			send_request(op_t'($urandom_range(3)), 16'($urandom), 5'($urandom_range(31)));
		end
	endtask

	// Result side: check each accepted result, then pick the next stall.
	initial begin
		pool_reply_t seen;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				seen = '{status, granted_handle, size_class, capacity_bytes, refs_after,
					class_in_use, class_peak, class_allocs, class_releases, failed_allocs};
				ledger.check_reply(seen);
			end
			if (want_hold) begin
				want_hold = 1'b0;
				hold_left = PRESSURE_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		ledger = new;
		ledger.clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Class boundaries: each class's first pop is its highest slot.
		send_request(OP_ALLOC, 16'd0, 5'd0);
		send_request(OP_ALLOC, 16'd128, 5'd0);
		send_request(OP_ALLOC, 16'd129, 5'd0);
		send_request(OP_ALLOC, 16'd512, 5'd0);
		send_request(OP_ALLOC, 16'd513, 5'd0);
		send_request(OP_ALLOC, 16'd1536, 5'd0);
		// Too large, just over and at the top of the field.
		send_request(OP_ALLOC, 16'd1537, 5'd0);
		send_request(OP_ALLOC, 16'hFFFF, 5'd31);
		// Unknown operation code.
		send_request(OP_NONE, 16'hFFFF, 5'd31);
		// Add a reference to the first small buffer handed out.
		send_request(OP_ADD_REF, 16'd0, 5'd7);
		// Handles past the last slot.
		send_request(OP_ADD_REF, 16'd0, 5'd24);
		send_request(OP_RELEASE, 16'd0, 5'd31);
		// Reference and release of a buffer still on its free list.
		send_request(OP_ADD_REF, 16'd0, 5'd0);
		send_request(OP_RELEASE, 16'd0, 5'd0);
		// Drop to one, to zero, then release once more while already free.
		send_request(OP_RELEASE, 16'd0, 5'd7);
		send_request(OP_RELEASE, 16'd0, 5'd7);
		send_request(OP_RELEASE, 16'd0, 5'd7);
		// The freed buffer sits on top of the small list again.
		send_request(OP_ALLOC, 16'd64, 5'd0);

		while (sent < TOTAL_ITEMS) begin
			pick = $urandom_range(99);
			if (!saturated && (pick < 2 || sent > 700))
				saturate_one();
			else if (pick < 7)
				exhaust_class(cls_t'($urandom_range(2)));
			else if (pick < 10)
				drain_pool();
			else
				send_mixed();
		end
		req_valid <= 1'b0;

		// Let the last results come out, then idle for SETTLE_CYCLES to catch strays.
		waited = 0;
		while (ledger.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ledger.pending() != 0) begin
			$error("%0d results never arrived", ledger.pending());
			ledger.errors++;
		end
		if (ledger.errors == 0)
			$display("tb_sized_buffer_pool_manager: clean");
		else
			$display("tb_sized_buffer_pool_manager: errors");
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		#2_000_000;
		$display("tb_sized_buffer_pool_manager: errors");
		$finish;
	end

endmodule
